>>> rtl/core/assert_macros.svh
// Assertion macros for the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge once reset has been released.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: assertion failed");

// Checked at every rising edge, during reset as well.
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("%m: assertion failed");

`endif

>>> rtl/core/qep_pkg.sv
package qep_pkg;

    localparam int CODE_W    = 2;
    localparam int DIV_W     = 8;
    localparam int ACC_W     = 9;
    localparam int POS_W     = 16;

    // Bit n is set when the transition {last code, new code} equals n.
    localparam logic [15:0] STEP_UP_MASK   = 16'h2814;
    localparam logic [15:0] STEP_DOWN_MASK = 16'h4182;

    localparam logic EVENT_POSITION  = 1'b0;
    localparam logic EVENT_DIRECTION = 1'b1;
    localparam logic DIR_UP          = 1'b0;
    localparam logic DIR_DOWN        = 1'b1;

    typedef enum logic [1:0] {
        CFG_STEP_DIVISOR = 2'd0,
        CFG_START_VALUE  = 2'd1,
        CFG_MINIMUM      = 2'd2,
        CFG_MAXIMUM      = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic pin_a;
        logic pin_b;
    } in_t;

    typedef struct packed {
        logic                    event_kind;
        logic signed [POS_W-1:0] position;
        logic                    direction;
    } out_t;

    typedef struct packed {
        logic code_valid;
        logic move;
        logic down;
    } step_t;

endpackage

>>> rtl/core/quadrature_encoder_position.sv
// Channel   Ports                                   Payload
// s_        s_valid, s_ready, s_data                qep_pkg::in_t (pin_a, pin_b)
// m_        m_valid, m_ready, m_data                qep_pkg::out_t
// cfg_      cfg_valid, cfg_ready, cfg_index, cfg_data   register index, 16-bit value
//
// An accepted request is held in the input register, then decoded into the result
// register, which is written only when the request makes a step. One request is
// taken every cycle while the result register does not stall; the position, code
// and step registers close their loop as it is decoded. The result register
// stalls the input register only while a result waits and m_ready is low. Reset
// is synchronous and active low; configuration writes are always taken.
module quadrature_encoder_position (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  qep_pkg::in_t                s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output qep_pkg::out_t               m_data,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [1:0]                  cfg_index,
    input  logic [qep_pkg::POS_W-1:0]   cfg_data
);

    logic                              in_valid_reg;
    logic                              in_valid_next;
    qep_pkg::in_t                      in_data_reg;
    logic                              out_valid_reg;
    logic                              out_valid_next;
    qep_pkg::out_t                     out_data_reg;
    logic [qep_pkg::CODE_W-1:0]        last_code_reg;
    logic signed [qep_pkg::ACC_W-1:0]  accum_reg;
    logic signed [qep_pkg::ACC_W-1:0]  accum_next;
    logic signed [qep_pkg::POS_W-1:0]  position_reg;
    logic signed [qep_pkg::POS_W-1:0]  position_next;
    logic [qep_pkg::DIV_W-1:0]         divisor_reg;
    logic signed [qep_pkg::POS_W-1:0]  minimum_reg;
    logic signed [qep_pkg::POS_W-1:0]  maximum_reg;

    logic                              out_free;
    logic                              process;
    logic                              cfg_write;
    logic [qep_pkg::CODE_W-1:0]        code;
    qep_pkg::step_t                    step;
    logic                              range_mode;
    qep_pkg::out_t                     result;

    assign out_free  = !out_valid_reg || m_ready;
    assign process   = in_valid_reg && out_free;
    assign s_ready   = !in_valid_reg || out_free;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_data_reg;
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign code      = {in_data_reg.pin_a, in_data_reg.pin_b};

    qep_step_decode u_step_decode (
        .last_code  (last_code_reg),
        .code       (code),
        .accum      (accum_reg),
        .divisor    (divisor_reg),
        .step       (step),
        .accum_next (accum_next)
    );

    qep_position_update u_position_update (
        .position      (position_reg),
        .minimum       (minimum_reg),
        .maximum       (maximum_reg),
        .down          (step.down),
        .range_mode    (range_mode),
        .position_next (position_next),
        .result        (result)
    );

    always_comb begin
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (process) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end

        if (process && step.move) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            last_code_reg <= '0;
            accum_reg     <= '0;
            position_reg  <= '0;
            divisor_reg   <= qep_pkg::DIV_W'(1);
            minimum_reg   <= '0;
            maximum_reg   <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;

            if (s_valid && s_ready) begin
                in_data_reg <= s_data;
            end

            if (process && step.move) begin
                out_data_reg <= result;
            end

            if (process && step.code_valid) begin
                last_code_reg <= code;
                accum_reg     <= accum_next;
            end

            if (cfg_write) begin
                unique case (cfg_index)
                    qep_pkg::CFG_STEP_DIVISOR: begin
                        divisor_reg <= cfg_data[qep_pkg::DIV_W-1:0];
                    end
                    qep_pkg::CFG_START_VALUE: begin
                        position_reg <= cfg_data;
                    end
                    qep_pkg::CFG_MINIMUM: begin
                        minimum_reg <= cfg_data;
                    end
                    qep_pkg::CFG_MAXIMUM: begin
                        maximum_reg <= cfg_data;
                    end
                    default: begin
                    end
                endcase
            end else if (process && step.move && range_mode) begin
                position_reg <= position_next;
            end
        end
    end

endmodule

>>> rtl/core/qep_step_decode.sv
module qep_step_decode (
    input  logic [qep_pkg::CODE_W-1:0]       last_code,
    input  logic [qep_pkg::CODE_W-1:0]       code,
    input  logic signed [qep_pkg::ACC_W-1:0] accum,
    input  logic [qep_pkg::DIV_W-1:0]        divisor,
    output qep_pkg::step_t                   step,
    output logic signed [qep_pkg::ACC_W-1:0] accum_next
);

    logic [2*qep_pkg::CODE_W-1:0]     transition;
    logic                             up;
    logic                             down;
    logic                             stepped;
    logic                             div_on;
    logic signed [qep_pkg::ACC_W:0]   sum;
    logic [qep_pkg::ACC_W:0]          mag;
    logic                             reached;

    always_comb begin
        transition = {last_code, code};
        up         = qep_pkg::STEP_UP_MASK[transition];
        down       = qep_pkg::STEP_DOWN_MASK[transition];
        stepped    = (code != '0) && (up || down);
        div_on     = divisor > qep_pkg::DIV_W'(1);
        sum        = {accum[qep_pkg::ACC_W-1], accum}
                   + (down ? {(qep_pkg::ACC_W+1){1'b1}} : (qep_pkg::ACC_W+1)'(1));
        mag        = sum[qep_pkg::ACC_W] ? (qep_pkg::ACC_W+1)'(-sum) : sum;
        reached    = mag >= {{(qep_pkg::ACC_W+1-qep_pkg::DIV_W){1'b0}}, divisor};

        step.code_valid = code != '0;
        step.move       = stepped && (!div_on || reached);
        step.down       = down;

        if (!stepped || !div_on) begin
            accum_next = accum;
        end else if (reached) begin
            accum_next = '0;
        end else begin
            accum_next = sum[qep_pkg::ACC_W-1:0];
        end
    end

endmodule

>>> rtl/core/qep_position_update.sv
module qep_position_update (
    input  logic signed [qep_pkg::POS_W-1:0] position,
    input  logic signed [qep_pkg::POS_W-1:0] minimum,
    input  logic signed [qep_pkg::POS_W-1:0] maximum,
    input  logic                             down,
    output logic                             range_mode,
    output logic signed [qep_pkg::POS_W-1:0] position_next,
    output qep_pkg::out_t                    result
);

    logic signed [qep_pkg::POS_W:0] moved;
    logic signed [qep_pkg::POS_W:0] min_ext;
    logic signed [qep_pkg::POS_W:0] max_ext;
    logic signed [qep_pkg::POS_W:0] clamped;

    always_comb begin
        range_mode = minimum != maximum;
        min_ext    = {minimum[qep_pkg::POS_W-1], minimum};
        max_ext    = {maximum[qep_pkg::POS_W-1], maximum};
        moved      = {position[qep_pkg::POS_W-1], position}
                   + (down ? {(qep_pkg::POS_W+1){1'b1}} : (qep_pkg::POS_W+1)'(1));

        // The upper bound is applied first, so an inverted range settles at minimum.
        clamped = moved;
        if (clamped > max_ext) begin
            clamped = max_ext;
        end
        if (clamped < min_ext) begin
            clamped = min_ext;
        end
        position_next = clamped[qep_pkg::POS_W-1:0];

        result.event_kind = range_mode ? qep_pkg::EVENT_POSITION : qep_pkg::EVENT_DIRECTION;
        result.position   = range_mode ? position_next : '0;
        result.direction  = down ? qep_pkg::DIR_DOWN : qep_pkg::DIR_UP;
    end

endmodule

>>> rtl/core/qep_checker.sv
`include "assert_macros.svh"

module qep_checker (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_ready,
    input  logic                        m_valid,
    input  logic                        m_ready,
    input  qep_pkg::out_t               m_data
);

    logic direction_shown;

    assign direction_shown = m_valid && (m_data.event_kind == qep_pkg::EVENT_DIRECTION);

    `ASSERT_ALWAYS(a_reset_clears_result, aclk, !aresetn |=> !m_valid)

    `ASSERT_CLK(a_result_held, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_data))

    `ASSERT_CLK(a_stall_only_on_result, aclk, aresetn, !s_ready |-> m_valid)

    `ASSERT_CLK(a_direction_has_no_position, aclk, aresetn, direction_shown |-> m_data.position == '0)

endmodule

bind quadrature_encoder_position qep_checker u_qep_checker (.*);

>>> verif/tb_quadrature_encoder_position.sv
`timescale 1ns / 100ps

module tb_quadrature_encoder_position;

    localparam logic [15:0] UP_TRANSITIONS   = 16'h2814;
    localparam logic [15:0] DOWN_TRANSITIONS = 16'h4182;
    localparam logic [1:0]  GRAY_CYCLE [4]   = '{2'b00, 2'b10, 2'b11, 2'b01};

    class position_scoreboard;
        logic [7:0]         divisor;
        logic signed [15:0] min_pos;
        logic signed [15:0] max_pos;
        logic signed [15:0] pos;
        logic [1:0]         prev_code;
        int                 accum;
        qep_pkg::out_t      expected_moves[$];
        int                 mismatches;

        function new();
            divisor    = 8'd1;
            min_pos    = '0;
            max_pos    = '0;
            pos        = '0;
            prev_code  = 2'b00;
            accum      = 0;
            mismatches = 0;
        endfunction

        function void note_config(input qep_pkg::cfg_index_t idx, input logic [15:0] value);
            case (idx)
                qep_pkg::CFG_STEP_DIVISOR: divisor = value[7:0];
                qep_pkg::CFG_START_VALUE:  pos     = value;
                qep_pkg::CFG_MINIMUM:      min_pos = value;
                qep_pkg::CFG_MAXIMUM:      max_pos = value;
                default: ;
            endcase
        endfunction

        function void note_sample(input qep_pkg::in_t smp);
            logic [1:0]    code;
            logic [3:0]    trans;
            int            delta;
            int            mag;
            int            next_pos;
            qep_pkg::out_t move;
            code = {smp.pin_a, smp.pin_b};
            if (code == 2'b00) return;
            trans     = {prev_code, code};
            prev_code = code;
            if (UP_TRANSITIONS[trans]) begin
                delta = 1;
            end else if (DOWN_TRANSITIONS[trans]) begin
                delta = -1;
            end else begin
                return;
            end
            if (divisor > 1) begin
                accum = accum + delta;
                mag   = (accum < 0) ? -accum : accum;
                if (mag < divisor) return;
                accum = 0;
            end
            if (min_pos != max_pos) begin
                next_pos = pos + delta;
                if (next_pos > max_pos) next_pos = max_pos;
                if (next_pos < min_pos) next_pos = min_pos;
                pos             = next_pos[15:0];
                move.event_kind = qep_pkg::EVENT_POSITION;
                move.position   = pos;
            end else begin
                move.event_kind = qep_pkg::EVENT_DIRECTION;
                move.position   = '0;
            end
            move.direction = (delta > 0) ? qep_pkg::DIR_UP : qep_pkg::DIR_DOWN;
            expected_moves.push_back(move);
        endfunction

        function void check_result(input qep_pkg::out_t got);
            qep_pkg::out_t want;
            if (expected_moves.size() == 0) begin
                $error("unexpected result: event_kind %0d position %0d direction %0d",
                       got.event_kind, got.position, got.direction);
                mismatches++;
                return;
            end
            want = expected_moves.pop_front();
            if (got.event_kind !== want.event_kind) begin
                $error("event_kind: expected %0d, got %0d", want.event_kind, got.event_kind);
                mismatches++;
            end
            if (got.position !== want.position) begin
                $error("position: expected %0d, got %0d", want.position, got.position);
                mismatches++;
            end
            if (got.direction !== want.direction) begin
                $error("direction: expected %0d, got %0d", want.direction, got.direction);
                mismatches++;
            end
        endfunction

        function int pending();
            return expected_moves.size();
        endfunction
    endclass

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                s_valid   = 1'b0;
    logic                s_ready;
    qep_pkg::in_t        s_data    = '0;
    logic                m_valid;
    logic                m_ready   = 1'b0;
    qep_pkg::out_t       m_data;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    qep_pkg::cfg_index_t cfg_index = qep_pkg::CFG_STEP_DIVISOR;
    logic [15:0]         cfg_data  = '0;

    position_scoreboard board = new();
    bit idle_on = 1'b0;
    int gray_pos = 0;
    int heading = 1;

    quadrature_encoder_position uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    task automatic send_code(input logic [1:0] code);
        qep_pkg::in_t smp;
        int           gap;
        smp.pin_a = code[1];
        smp.pin_b = code[0];
        gap = idle_on ? $urandom_range(0, 3) : 0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= smp;
        do @(posedge aclk); while (s_ready !== 1'b1);
        board.note_sample(smp);
    endtask

    // Samples with no step leave the pipeline without a result, so the task keeps
    // waiting after the last result so they drain before the registers are touched.
    task automatic wait_idle();
        if (s_valid) s_valid <= 1'b0;
        while (board.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input qep_pkg::cfg_index_t idx, input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        board.note_config(idx, value);
    endtask

    task automatic set_regs(input logic [15:0] div_word, input logic [15:0] start,
                            input logic [15:0] lo, input logic [15:0] hi,
                            input bit load_start);
        write_reg(qep_pkg::CFG_STEP_DIVISOR, div_word);
        write_reg(qep_pkg::CFG_MINIMUM, lo);
        write_reg(qep_pkg::CFG_MAXIMUM, hi);
        if (load_start) write_reg(qep_pkg::CFG_START_VALUE, start);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_settings(input int div);
        logic [15:0] lo;
        logic [15:0] hi;
        logic [15:0] start;
        int          kind;
        if (div < 0) begin
            div = ($urandom_range(0, 5) == 5) ? $urandom_range(0, 255) : $urandom_range(0, 4);
        end
        kind = $urandom_range(0, 3);
        case (kind)
            0: begin
                lo = 16'h8000;
                hi = 16'h7FFF;
            end
            1: begin
                lo = 16'($urandom);
                hi = lo + 16'($urandom_range(1, 15));
            end
            2: begin
                lo = 16'($urandom);
                hi = lo;
            end
            default: begin
                lo = 16'($urandom);
                hi = 16'($urandom);
            end
        endcase
        if ($urandom_range(0, 3) == 0) begin
            start = 16'($urandom);
        end else if ($urandom_range(0, 1) == 1) begin
            start = lo + 16'($urandom_range(0, 15));
        end else begin
            start = hi - 16'($urandom_range(0, 3));
        end
        set_regs({8'($urandom), 8'(div)}, start, lo, hi, $urandom_range(0, 2) != 0);
    endtask

    // Mostly a clean quadrature walk, and only that when steady is set; otherwise the
    // rest are reversals, repeats and arbitrary pin pairs.
    task automatic walk(input int count, input bit steady);
        int r;
        heading = ($urandom_range(0, 1) == 1) ? 1 : -1;
        repeat (count) begin
            r = $urandom_range(0, 99);
            if (steady || r < 70) begin
                gray_pos = (gray_pos + heading) & 3;
            end else if (r < 85) begin
                heading  = -heading;
                gray_pos = (gray_pos + heading) & 3;
            end
            if (!steady && r >= 95) begin
                send_code(2'($urandom));
            end else begin
                send_code(GRAY_CYCLE[gray_pos]);
            end
            if (!steady && $urandom_range(0, 49) == 0) wait_idle();
        end
    endtask

    initial begin : result_sink
        int stall;
        wait (aresetn === 1'b1);
        forever begin
            stall = idle_on ? $urandom_range(0, 3) : 0;
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1 || m_ready !== 1'b1);
            board.check_result(m_data);
        end
    end

    initial begin : stimulus
        logic [1:0] opening [13] = '{2'd2, 2'd0, 2'd2, 2'd3, 2'd0, 2'd3, 2'd1, 2'd1,
                                     2'd3, 2'd2, 2'd1, 2'd0, 2'd2};
        logic [1:0] upper_edge [5] = '{2'd3, 2'd1, 2'd0, 2'd2, 2'd3};
        logic [1:0] lower_edge [5] = '{2'd2, 2'd0, 2'd1, 2'd3, 2'd2};
        logic [1:0] halved [4] = '{2'd3, 2'd2, 2'd3, 2'd1};
        int ph;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (opening[i]) send_code(opening[i]);
        wait_idle();
        set_regs(16'hA500, 16'h7FFE, 16'h8000, 16'h7FFF, 1'b1);
        foreach (upper_edge[i]) send_code(upper_edge[i]);
        wait_idle();
        set_regs(16'h5A00, 16'h8001, 16'h8000, 16'h7FFF, 1'b1);
        foreach (lower_edge[i]) send_code(lower_edge[i]);
        wait_idle();
        set_regs(16'h0001, 16'h0000, 16'd100, -16'sd100, 1'b1);
        send_code(2'b11);
        send_code(2'b10);
        wait_idle();
        set_regs(16'hFF02, 16'h0000, -16'sd5, 16'sd5, 1'b1);
        foreach (halved[i]) send_code(halved[i]);

        for (ph = 0; ph < 10; ph++) begin
            wait_idle();
            idle_on = ($urandom_range(0, 3) != 0);
            if (ph == 0) begin
                random_settings($urandom_range(100, 130));
                walk(200, 1'b1);
            end else begin
                random_settings((ph == 1) ? 255 : -1);
                walk($urandom_range(15, 30), 1'b0);
            end
        end
        wait_idle();

        if (board.mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
